/* design/mnpm_pkg.sv */
package mnpm_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int COORD_W = 16;
  localparam int LOC_W   = 2 * COORD_W;
  localparam int DIST_W  = COORD_W + 1;

  localparam logic [1:0] OP_WR_REQ = 2'd0;
  localparam logic [1:0] OP_WR_SRV = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;

  localparam logic REG_REQ_COUNT = 1'b0;
  localparam logic REG_SRV_COUNT = 1'b1;

  // one slot of the scan pipeline, aligned with the location read data
  typedef struct packed {
    logic             live;   // slot was issued by the sequencer
    logic             en;     // entry is ready and takes part
    logic             first;  // first slot of an inner scan
    logic             last;   // last slot of an inner scan
    logic [IDX_W-1:0] idx;
  } mnpm_tag_t;

  // running nearest-entry result of the distance unit
  typedef struct packed {
    logic             done;   // one-cycle pulse after the last slot
    logic             have;
    logic [IDX_W-1:0] idx;
  } mnpm_best_t;

endpackage

/* design/mnpm_loc_ram.sv */
module mnpm_loc_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [mnpm_pkg::IDX_W-1:0]    wr_addr,
  input  logic [mnpm_pkg::LOC_W-1:0]    wr_data,
  input  logic [mnpm_pkg::IDX_W-1:0]    rd_addr,
  output logic [mnpm_pkg::LOC_W-1:0]    rd_data
);

  logic [mnpm_pkg::LOC_W-1:0] mem [mnpm_pkg::ENTRIES];
  logic [mnpm_pkg::LOC_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/mnpm_dist.sv */
module mnpm_dist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mnpm_pkg::mnpm_tag_t           tag_i,
  input  logic [mnpm_pkg::LOC_W-1:0]    loc_a,
  input  logic [mnpm_pkg::LOC_W-1:0]    loc_b,
  output mnpm_pkg::mnpm_best_t          best_o
);

  logic [mnpm_pkg::COORD_W-1:0] ax, ay, bx, by, dx, dy;
  logic [mnpm_pkg::DIST_W-1:0]  dist_sum;

  mnpm_pkg::mnpm_tag_t          tag_r;
  logic [mnpm_pkg::DIST_W-1:0]  d_r;
  logic                         have_r, have_nxt, have_cur, take;
  logic                         done_r;
  logic [mnpm_pkg::DIST_W-1:0]  best_d_r;
  logic [mnpm_pkg::IDX_W-1:0]   best_idx_r;

  // Manhattan distance, registered before the compare
  always_comb begin
    ax = loc_a[mnpm_pkg::COORD_W-1:0];
    ay = loc_a[mnpm_pkg::LOC_W-1:mnpm_pkg::COORD_W];
    bx = loc_b[mnpm_pkg::COORD_W-1:0];
    by = loc_b[mnpm_pkg::LOC_W-1:mnpm_pkg::COORD_W];
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    dist_sum = {1'b0, dx} + {1'b0, dy};
  end

  // strict less-than keeps the lowest index on ties
  always_comb begin
    have_cur = tag_r.first ? 1'b0 : have_r;
    take     = tag_r.live && tag_r.en && (!have_cur || d_r < best_d_r);
    have_nxt = tag_r.live ? (take || have_cur) : have_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= '0;
      have_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      tag_r  <= tag_i;
      have_r <= have_nxt;
      done_r <= tag_r.live && tag_r.last;
    end
    d_r <= dist_sum;
    if (take) begin
      best_d_r   <= d_r;
      best_idx_r <= tag_r.idx;
    end
  end

  assign best_o = '{done: done_r, have: have_r, idx: best_idx_r};

endmodule

/* design/mutual_nearest_pair_matcher_top.sv */
// Mutual nearest pair matcher.
// Input channel (in_*): one beat is a command. Opcode write-requester or
// write-server stores x,y and a ready flag into one entry (ignored at or above
// the entry count); opcode match pairs the first server, in index order, whose
// nearest ready requester has that server as its own nearest (Manhattan
// distance, ties to the lowest index), and clears both ready flags.
// Output channel (out_*): exactly one beat per input beat. out_match_possible
// reflects the ready flags after that command.
// Config port (cfg_*): entry counts; the user must write them only while the
// block is idle, as the block does not enforce it. Writes, no-op commands and
// a match with nothing possible answer in the cycle after acceptance. A match
// runs two passes through one shared distance/compare unit, one pair per cycle
// while a scan runs; pass one finds each ready requester's nearest server.
// in_ready is low while a match runs. A result waits in the output register
// when out_ready is low; the next command is taken at the beat that drains it.
// Reset clears all ready flags, both counts and the sequencer; location and
// nearest-server memories are not cleared (ready entries were always written).
module mutual_nearest_pair_matcher_top (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [5:0]                  in_entry_index,
  input  logic [15:0]                 in_pos_x,
  input  logic [15:0]                 in_pos_y,
  input  logic                        in_is_ready,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_matched,
  output logic [5:0]                  out_requester_index,
  output logic [5:0]                  out_server_index,
  output logic                        out_match_possible,

  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [6:0]                  cfg_wdata
);

  localparam int IW = mnpm_pkg::IDX_W;
  localparam int CW = mnpm_pkg::CNT_W;
  localparam int N  = mnpm_pkg::ENTRIES;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_P1_OUTER = 3'd1;
  localparam logic [2:0] S_P1_SCAN  = 3'd2;
  localparam logic [2:0] S_P1_DRAIN = 3'd3;
  localparam logic [2:0] S_P2_OUTER = 3'd4;
  localparam logic [2:0] S_P2_SCAN  = 3'd5;
  localparam logic [2:0] S_P2_DRAIN = 3'd6;
  localparam logic [2:0] S_P2_CHECK = 3'd7;

  // config
  logic [CW-1:0] req_cnt_r, srv_cnt_r;
  logic [CW-1:0] nr_live, ns_live;

  // sequencer and flags
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] o_r, o_nxt;       // outer index
  logic [CW-1:0] k_r, k_nxt;       // inner issue index
  logic [N-1:0]  req_rdy_r, req_rdy_nxt;
  logic [N-1:0]  srv_rdy_r, srv_rdy_nxt;
  logic [N-1:0]  req_mask, srv_mask;
  logic          possible;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_matched_r, out_matched_nxt;
  logic [IW-1:0] out_ri_r, out_ri_nxt;
  logic [IW-1:0] out_si_r, out_si_nxt;

  // datapath
  logic                   in_acc;
  logic                   phase1;
  logic [CW-1:0]          scan_n;
  logic                   scan_last;
  logic                   req_wr_en, srv_wr_en;
  logic [mnpm_pkg::LOC_W-1:0] wr_loc;
  logic [IW-1:0]          req_rd_addr, srv_rd_addr;
  logic [mnpm_pkg::LOC_W-1:0] req_loc, srv_loc;
  mnpm_pkg::mnpm_tag_t    tag_issue, tag_q_r;
  mnpm_pkg::mnpm_best_t   best;
  logic [IW-1:0]          nearest_mem [N];
  logic [IW-1:0]          nearest_rd_r;
  logic                   near_wr_en;

  // counts above the table size saturate
  assign nr_live = (req_cnt_r > CW'(N)) ? CW'(N) : req_cnt_r;
  assign ns_live = (srv_cnt_r > CW'(N)) ? CW'(N) : srv_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_cnt_r <= '0;
      srv_cnt_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == mnpm_pkg::REG_REQ_COUNT) begin
        req_cnt_r <= cfg_wdata;
      end else begin
        srv_cnt_r <= cfg_wdata;
      end
    end
  end

  // only entries below the live count take part
  always_comb begin
    for (int i = 0; i < N; i++) begin
      req_mask[i] = (CW'(i) < nr_live);
      srv_mask[i] = (CW'(i) < ns_live);
    end
  end

  assign possible = (|(req_rdy_r & req_mask)) && (|(srv_rdy_r & srv_mask));

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  // location tables: x in the low half, y in the high half
  assign wr_loc    = {in_pos_y[mnpm_pkg::COORD_W-1:0], in_pos_x[mnpm_pkg::COORD_W-1:0]};
  assign req_wr_en = in_acc && (in_opcode == mnpm_pkg::OP_WR_REQ) &&
                     ({1'b0, in_entry_index} < nr_live);
  assign srv_wr_en = in_acc && (in_opcode == mnpm_pkg::OP_WR_SRV) &&
                     ({1'b0, in_entry_index} < ns_live);

  // pass one: outer requester, inner server; pass two the other way round
  assign phase1      = (state_r == S_P1_OUTER) || (state_r == S_P1_SCAN) ||
                       (state_r == S_P1_DRAIN);
  assign req_rd_addr = phase1 ? o_r[IW-1:0] : k_r[IW-1:0];
  assign srv_rd_addr = phase1 ? k_r[IW-1:0] : o_r[IW-1:0];
  assign scan_n      = phase1 ? ns_live : nr_live;
  assign scan_last   = (k_r == scan_n - CW'(1));

  mnpm_loc_ram u_req_ram (
    .clk     (clk),
    .wr_en   (req_wr_en),
    .wr_addr (in_entry_index),
    .wr_data (wr_loc),
    .rd_addr (req_rd_addr),
    .rd_data (req_loc)
  );

  mnpm_loc_ram u_srv_ram (
    .clk     (clk),
    .wr_en   (srv_wr_en),
    .wr_addr (in_entry_index),
    .wr_data (wr_loc),
    .rd_addr (srv_rd_addr),
    .rd_data (srv_loc)
  );

  // scan slot, registered to line up with the RAM read data
  always_comb begin
    tag_issue       = '0;
    tag_issue.live  = (state_r == S_P1_SCAN) || (state_r == S_P2_SCAN);
    tag_issue.en    = phase1 ? srv_rdy_r[k_r[IW-1:0]] : req_rdy_r[k_r[IW-1:0]];
    tag_issue.first = (k_r == '0);
    tag_issue.last  = scan_last;
    tag_issue.idx   = k_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_q_r <= '0;
    end else begin
      tag_q_r <= tag_issue;
    end
  end

  mnpm_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (tag_q_r),
    .loc_a  (req_loc),
    .loc_b  (srv_loc),
    .best_o (best)
  );

  // nearest server of each ready requester, filled by pass one
  assign near_wr_en = (state_r == S_P1_DRAIN) && best.done;

  always_ff @(posedge clk) begin
    if (near_wr_en) begin
      nearest_mem[o_r[IW-1:0]] <= best.idx;
    end
    nearest_rd_r <= nearest_mem[best.idx];
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    o_nxt           = o_r;
    k_nxt           = k_r;
    req_rdy_nxt     = req_rdy_r;
    srv_rdy_nxt     = srv_rdy_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_matched_nxt = out_matched_r;
    out_ri_nxt      = out_ri_r;
    out_si_nxt      = out_si_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (req_wr_en) begin
            req_rdy_nxt[in_entry_index] = in_is_ready;
          end
          if (srv_wr_en) begin
            srv_rdy_nxt[in_entry_index] = in_is_ready;
          end
          if (in_opcode == mnpm_pkg::OP_MATCH && possible) begin
            state_nxt = S_P1_OUTER;
            o_nxt     = '0;
          end else begin
            out_valid_nxt   = 1'b1;
            out_matched_nxt = 1'b0;
            out_ri_nxt      = '0;
            out_si_nxt      = '0;
          end
        end
      end
      S_P1_OUTER: begin
        if (o_r == nr_live) begin
          state_nxt = S_P2_OUTER;
          o_nxt     = '0;
        end else if (req_rdy_r[o_r[IW-1:0]]) begin
          state_nxt = S_P1_SCAN;
          k_nxt     = '0;
        end else begin
          o_nxt = o_r + CW'(1);
        end
      end
      S_P1_SCAN: begin
        if (scan_last) begin
          state_nxt = S_P1_DRAIN;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_P1_DRAIN: begin
        if (best.done) begin
          state_nxt = S_P1_OUTER;
          o_nxt     = o_r + CW'(1);
        end
      end
      S_P2_OUTER: begin
        if (o_r == ns_live) begin
          // no mutual pair; cannot happen with a ready entry on both sides
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_matched_nxt = 1'b0;
          out_ri_nxt      = '0;
          out_si_nxt      = '0;
        end else if (srv_rdy_r[o_r[IW-1:0]]) begin
          state_nxt = S_P2_SCAN;
          k_nxt     = '0;
        end else begin
          o_nxt = o_r + CW'(1);
        end
      end
      S_P2_SCAN: begin
        if (scan_last) begin
          state_nxt = S_P2_DRAIN;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_P2_DRAIN: begin
        if (best.done) begin
          state_nxt = S_P2_CHECK;
        end
      end
      S_P2_CHECK: begin
        if (best.have && nearest_rd_r == o_r[IW-1:0]) begin
          req_rdy_nxt[best.idx]    = 1'b0;
          srv_rdy_nxt[o_r[IW-1:0]] = 1'b0;
          state_nxt                = S_IDLE;
          out_valid_nxt            = 1'b1;
          out_matched_nxt          = 1'b1;
          out_ri_nxt               = best.idx;
          out_si_nxt               = o_r[IW-1:0];
        end else begin
          state_nxt = S_P2_OUTER;
          o_nxt     = o_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      o_r         <= '0;
      k_r         <= '0;
      req_rdy_r   <= '0;
      srv_rdy_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      o_r         <= o_nxt;
      k_r         <= k_nxt;
      req_rdy_r   <= req_rdy_nxt;
      srv_rdy_r   <= srv_rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_matched_r <= out_matched_nxt;
    out_ri_r      <= out_ri_nxt;
    out_si_r      <= out_si_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_matched         = out_matched_r;
  assign out_requester_index = out_ri_r;
  assign out_server_index    = out_si_r;
  // flags cannot change while a beat waits, so this is stable under stall
  assign out_match_possible  = possible;

`ifndef SYNTH
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending while match runs");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_matched_r) |-> (out_ri_r == '0 && out_si_r == '0))
    else $error("nonzero indices without a match");

  a_pair_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_matched_r) |->
      (!req_rdy_r[out_ri_r] && !srv_rdy_r[out_si_r]))
    else $error("matched pair still marked ready");

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    best.done |-> (state_r == S_P1_DRAIN || state_r == S_P2_DRAIN))
    else $error("distance unit finished outside a drain");

  a_check_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P2_CHECK) |-> best.have)
    else $error("server scan found no ready requester");
`endif

endmodule

/* tb/tb_mutual_nearest_pair_matcher_top.sv */
module tb_mutual_nearest_pair_matcher_top;

  localparam int ENTRIES = mnpm_pkg::ENTRIES;
  localparam int IDX_W   = mnpm_pkg::IDX_W;
  localparam int CNT_W   = mnpm_pkg::CNT_W;
  localparam int COORD_W = mnpm_pkg::COORD_W;
  localparam int DIST_W  = mnpm_pkg::DIST_W;

  // opcode that the block leaves unused; it must answer with a plain status beat
  localparam logic [1:0] OP_NOP = 2'd3;

  // Watchdog bound: even if every command were a full-size match, the run stays
  // well below this.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 250;

  // one expected result beat
  typedef struct packed {
    logic             matched;
    logic [IDX_W-1:0] req_idx;
    logic [IDX_W-1:0] srv_idx;
    logic             possible;
  } pair_result_t;

  logic               clk;
  logic               rst_n;

  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [IDX_W-1:0]   in_entry_index;
  logic [COORD_W-1:0] in_pos_x;
  logic [COORD_W-1:0] in_pos_y;
  logic               in_is_ready;

  logic               out_valid;
  logic               out_ready;
  logic               out_matched;
  logic [IDX_W-1:0]   out_requester_index;
  logic [IDX_W-1:0]   out_server_index;
  logic               out_match_possible;

  logic               cfg_wr_en;
  logic               cfg_index;
  logic [CNT_W-1:0]   cfg_wdata;

  mutual_nearest_pair_matcher_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_entry_index      (in_entry_index),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_is_ready         (in_is_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_matched         (out_matched),
    .out_requester_index (out_requester_index),
    .out_server_index    (out_server_index),
    .out_match_possible  (out_match_possible),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the two tables and the counts, updated at the same edges
  // at which the block takes a beat or a register write.
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] req_x    [ENTRIES];
  logic [COORD_W-1:0] req_y    [ENTRIES];
  logic [COORD_W-1:0] srv_x    [ENTRIES];
  logic [COORD_W-1:0] srv_y    [ENTRIES];
  logic               req_rdy  [ENTRIES];
  logic               srv_rdy  [ENTRIES];
  logic [IDX_W-1:0]   req_near [ENTRIES];
  int unsigned        req_cnt;
  int unsigned        srv_cnt;

  pair_result_t       pending_pairs [$];
  int unsigned        mismatches;
  int unsigned        results_seen;
  int unsigned        cycle_no;

  bit                 gaps_on  = 1'b1;  // random idling on both sides
  bit                 hold_ask = 1'b0;  // asks the receiver for a long hold-off
  int unsigned        hold_left = 0;

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // counts above the table size saturate
  function automatic int unsigned live(int unsigned cnt);
    return (cnt > ENTRIES) ? ENTRIES : cnt;
  endfunction

  // Manhattan distance, one bit wider than a coordinate
  function automatic logic [DIST_W-1:0] span(int unsigned r, int unsigned s);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    dx = (req_x[r] > srv_x[s]) ? req_x[r] - srv_x[s] : srv_x[s] - req_x[r];
    dy = (req_y[r] > srv_y[s]) ? req_y[r] - srv_y[s] : srv_y[s] - req_y[r];
    return {1'b0, dx} + {1'b0, dy};
  endfunction

  // at least one ready entry in use on each side
  function automatic logic pairing_possible();
    logic any_req;
    logic any_srv;
    any_req = 1'b0;
    any_srv = 1'b0;
    for (int i = 0; i < live(req_cnt); i++) any_req |= req_rdy[i];
    for (int i = 0; i < live(srv_cnt); i++) any_srv |= srv_rdy[i];
    return any_req && any_srv;
  endfunction

  // applies one command to the shadow tables and returns the expected beat
  function automatic pair_result_t predict_pairing(logic [1:0] op, logic [IDX_W-1:0] idx,
                                                   logic [COORD_W-1:0] x,
                                                   logic [COORD_W-1:0] y, logic rdy);
    pair_result_t      res;
    int unsigned       nr;
    int unsigned       ns;
    int unsigned       pick;
    logic              have;
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] d;
    res = '0;
    nr  = live(req_cnt);
    ns  = live(srv_cnt);
    case (op)
      mnpm_pkg::OP_WR_REQ: begin
        if (idx < nr) begin
          req_x[idx]   = x;
          req_y[idx]   = y;
          req_rdy[idx] = rdy;
        end
      end
      mnpm_pkg::OP_WR_SRV: begin
        if (idx < ns) begin
          srv_x[idx]   = x;
          srv_y[idx]   = y;
          srv_rdy[idx] = rdy;
        end
      end
      mnpm_pkg::OP_MATCH: begin
        if (pairing_possible()) begin
          // nearest ready server of every ready requester, lowest index on ties
          for (int r = 0; r < nr; r++) begin
            if (!req_rdy[r]) continue;
            have = 1'b0;
            best = '0;
            for (int s = 0; s < ns; s++) begin
              if (!srv_rdy[s]) continue;
              d = span(r, s);
              if (!have || d < best) begin
                have        = 1'b1;
                best        = d;
                req_near[r] = IDX_W'(s);
              end
            end
          end
          // first server, in index order, whose nearest requester points back
          for (int s = 0; s < ns && !res.matched; s++) begin
            if (!srv_rdy[s]) continue;
            have = 1'b0;
            best = '0;
            pick = 0;
            for (int r = 0; r < nr; r++) begin
              if (!req_rdy[r]) continue;
              d = span(r, s);
              if (!have || d < best) begin
                have = 1'b1;
                best = d;
                pick = r;
              end
            end
            if (have && req_near[pick] == IDX_W'(s)) begin
              req_rdy[pick] = 1'b0;
              srv_rdy[s]    = 1'b0;
              res.matched   = 1'b1;
              res.req_idx   = IDX_W'(pick);
              res.srv_idx   = IDX_W'(s);
            end
          end
        end
      end
      default: ;
    endcase
    res.possible = pairing_possible();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: one process sees every beat at the rising edge. Result beats
  // are matched first, since a beat accepted at this edge cannot answer yet.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what);
    mismatches++;
    $display("mismatch, result %0d: %s", results_seen, what);
  endtask

  always @(posedge clk) begin
    pair_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_pairs.size() == 0) begin
          flag_mismatch("result beat with nothing pending");
        end else begin
          want = pending_pairs.pop_front();
          if (out_matched !== want.matched)
            flag_mismatch($sformatf("matched %b, want %b", out_matched, want.matched));
          if (out_requester_index !== want.req_idx)
            flag_mismatch($sformatf("requester_index %0d, want %0d",
                                    out_requester_index, want.req_idx));
          if (out_server_index !== want.srv_idx)
            flag_mismatch($sformatf("server_index %0d, want %0d",
                                    out_server_index, want.srv_idx));
          if (out_match_possible !== want.possible)
            flag_mismatch($sformatf("match_possible %b, want %b",
                                    out_match_possible, want.possible));
        end
      end
      if (in_valid && in_ready)
        pending_pairs = {pending_pairs,
                         predict_pairing(in_opcode, in_entry_index,
                                         in_pos_x, in_pos_y, in_is_ready)};
      if (cfg_wr_en) begin
        if (cfg_index == mnpm_pkg::REG_REQ_COUNT) req_cnt = 32'(cfg_wdata);
        else                                      srv_cnt = 32'(cfg_wdata);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off counted here when asked for.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask) begin
        hold_left = HOLD_CYCLES;
        hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !(gaps_on && $urandom_range(99) < 14);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side helpers
  // ---------------------------------------------------------------------------
  // one command beat; valid holds until the block takes it
  task automatic send_cmd(logic [1:0] op, logic [IDX_W-1:0] idx, logic [COORD_W-1:0] x,
                          logic [COORD_W-1:0] y, logic rdy);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_opcode      = op;
    in_entry_index = idx;
    in_pos_x       = x;
    in_pos_y       = y;
    in_is_ready    = rdy;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every pending beat has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register writes only while the block is idle
  task automatic set_counts(logic [CNT_W-1:0] reqs, logic [CNT_W-1:0] srvs);
    drain();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = mnpm_pkg::REG_REQ_COUNT;
    cfg_wdata = reqs;
    @(negedge clk);
    cfg_index = mnpm_pkg::REG_SRV_COUNT;
    cfg_wdata = srvs;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // mostly full-range values, some clustered near zero to force ties, some extremes
  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned roll;
    roll = $urandom_range(7);
    if (roll < 4) return COORD_W'($urandom);
    if (roll < 6) return COORD_W'($urandom_range(7));
    return (roll == 7) ? '1 : '0;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int unsigned n);
    return (n == 0) ? IDX_W'($urandom_range(ENTRIES - 1)) : IDX_W'($urandom_range(n - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // counts are zero after reset: nothing is in use, writes are dropped
  task automatic test_empty_tables();
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
    send_cmd(mnpm_pkg::OP_WR_REQ, '0, 16'h1234, 16'h4321, 1'b1);
    send_cmd(OP_NOP, '1, '1, '1, 1'b1);
  endtask

  task automatic test_extremes();
    set_counts(CNT_W'(ENTRIES), CNT_W'(ENTRIES));
    // opposite corners: distance needs the carry bit
    send_cmd(mnpm_pkg::OP_WR_REQ, IDX_W'(ENTRIES - 1), '1, '1, 1'b1);
    send_cmd(mnpm_pkg::OP_WR_SRV, '0, '0, '0, 1'b1);
    send_cmd(OP_NOP, '0, '0, '0, 1'b0);
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
    // ties on both sides go to the lowest index
    send_cmd(mnpm_pkg::OP_WR_REQ, 6'd0, 16'd0, 16'd0, 1'b1);
    send_cmd(mnpm_pkg::OP_WR_REQ, 6'd1, 16'd0, 16'd0, 1'b1);
    send_cmd(mnpm_pkg::OP_WR_SRV, 6'd5, 16'd3, 16'd4, 1'b1);
    send_cmd(mnpm_pkg::OP_WR_SRV, 6'd6, 16'd4, 16'd3, 1'b1);
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
    // first server is not mutual, the second one is
    send_cmd(mnpm_pkg::OP_WR_SRV, 6'd0, 16'd0, 16'd0, 1'b1);
    send_cmd(mnpm_pkg::OP_WR_SRV, 6'd1, 16'd100, 16'd100, 1'b1);
    send_cmd(mnpm_pkg::OP_WR_REQ, 6'd0, 16'd90, 16'd90, 1'b1);
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
    // a ready entry withdrawn again leaves no requester: no match
    send_cmd(mnpm_pkg::OP_WR_REQ, 6'd2, 16'd5, 16'd5, 1'b1);
    send_cmd(mnpm_pkg::OP_WR_REQ, 6'd2, 16'd5, 16'd5, 1'b0);
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
  endtask

  // entries outlive count changes; writes past the count are dropped
  task automatic test_count_changes();
    set_counts(7'd2, 7'd2);
    send_cmd(mnpm_pkg::OP_WR_REQ, 6'd1, 16'd1, 16'd1, 1'b1);
    set_counts(7'd1, 7'd2);
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
    send_cmd(mnpm_pkg::OP_WR_REQ, 6'd1, 16'hbeef, 16'hcafe, 1'b0);
    set_counts('1, '1);
    send_cmd(mnpm_pkg::OP_WR_SRV, IDX_W'(ENTRIES - 1), 16'h8000, 16'h0001, 1'b1);
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering beats
  task automatic test_backpressure();
    set_counts(7'd8, 7'd8);
    @(posedge clk);
    hold_ask = 1'b1;
    repeat (5) begin
      send_cmd(mnpm_pkg::OP_WR_REQ, pick_index(8), rand_coord(), rand_coord(), 1'b1);
      send_cmd(mnpm_pkg::OP_WR_SRV, pick_index(8), rand_coord(), rand_coord(), 1'b1);
    end
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
    send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
  endtask

  // Mostly well-formed rounds (a few ready entries on both sides, then one or
  // two matches); the rest is noise. Dropped beats do not count to the budget.
  task automatic run_phase(logic [CNT_W-1:0] reqs, logic [CNT_W-1:0] srvs,
                           int unsigned budget);
    int unsigned nr;
    int unsigned ns;
    int unsigned used;
    int unsigned pairs;
    int unsigned roll;
    set_counts(reqs, srvs);
    nr   = live(32'(reqs));
    ns   = live(32'(srvs));
    used = 0;
    while (used < budget) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        pairs = $urandom_range(1, 3);
        repeat (pairs) begin
          send_cmd(mnpm_pkg::OP_WR_REQ, pick_index(nr), rand_coord(), rand_coord(), 1'b1);
          send_cmd(mnpm_pkg::OP_WR_SRV, pick_index(ns), rand_coord(), rand_coord(), 1'b1);
        end
        send_cmd(mnpm_pkg::OP_MATCH, pick_index(ENTRIES), rand_coord(), rand_coord(),
                 1'($urandom));
        used += 2 * pairs + 1;
        if ($urandom_range(1)) begin
          send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
          used++;
        end
      end else if (roll < 78) begin
        send_cmd(OP_NOP, pick_index(ENTRIES), rand_coord(), rand_coord(), 1'($urandom));
      end else if (roll < 86 && (nr < ENTRIES || ns < ENTRIES)) begin
        // write past the count on a side that has room for one
        if (nr < ENTRIES)
          send_cmd(mnpm_pkg::OP_WR_REQ, IDX_W'($urandom_range(ENTRIES - 1, nr)),
                   rand_coord(), rand_coord(), 1'b1);
        else
          send_cmd(mnpm_pkg::OP_WR_SRV, IDX_W'($urandom_range(ENTRIES - 1, ns)),
                   rand_coord(), rand_coord(), 1'b1);
      end else if (roll < 94) begin
        send_cmd($urandom_range(1) ? mnpm_pkg::OP_WR_SRV : mnpm_pkg::OP_WR_REQ,
                 pick_index(ns < nr ? ns : nr), rand_coord(), rand_coord(), 1'b0);
        used++;
      end else begin
        send_cmd(mnpm_pkg::OP_MATCH, '0, '0, '0, 1'b0);
        used++;
      end
    end
  endtask

  task automatic test_random_traffic();
    // full-size tables make each match long, so only a short phase there
    run_phase(CNT_W'(ENTRIES), CNT_W'(ENTRIES), 5);
    run_phase(CNT_W'($urandom_range(2, 12)), CNT_W'($urandom_range(2, 12)), 6);
    run_phase(7'd1, 7'd1, 4);
    run_phase(7'd0, 7'd6, 4);
    run_phase(7'd9, 7'd0, 4);
    run_phase(7'd3, 7'd10, 6);
    run_phase('1, 7'd5, 4);
    // long stretch with no idling on either side
    gaps_on = 1'b0;
    run_phase(CNT_W'($urandom_range(2, 12)), CNT_W'($urandom_range(2, 12)), 12);
    gaps_on = 1'b1;
    run_phase(CNT_W'($urandom_range(1, 16)), CNT_W'($urandom_range(1, 16)), 6);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_NOP;
    in_entry_index = '0;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_is_ready    = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = mnpm_pkg::REG_REQ_COUNT;
    cfg_wdata      = '0;
    req_cnt        = 0;
    srv_cnt        = 0;
    mismatches     = 0;
    results_seen   = 0;
    cycle_no       = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      req_x[i]    = '0;
      req_y[i]    = '0;
      srv_x[i]    = '0;
      srv_y[i]    = '0;
      req_rdy[i]  = 1'b0;
      srv_rdy[i]  = 1'b0;
      req_near[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_tables();
    test_extremes();
    test_count_changes();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
